// ===== src/tfr_pkg.sv =====
package tfr_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SOF_BYTE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHK_OFFSET = 1'd1;

  // Register reset values.
  localparam logic [BYTE_W-1:0] SOF_BYTE_RST   = 8'd36;
  localparam logic [BYTE_W-1:0] CHK_OFFSET_RST = 8'd0;

  // Operation codes of an input beat.
  localparam logic OP_RX_BYTE = 1'b0;
  localparam logic OP_FETCH   = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_COLLECT,
    PH_HELD
  } tfr_phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_STR_RD,
    ST_STR_EMIT
  } tfr_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic byte_op;     // process a received byte and post its result
    logic fetch_start; // back to hunt, clear counters and running sum
    logic rd_en;       // read the frame store at the sweep index
    logic acc;         // add read byte to the sum, or check it at the checksum slot
    logic emit;        // post one payload result and step the sweep index
  } tfr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;    // output register can take a result this cycle
    logic idx_is_chk;  // sweep index sits on the checksum slot
    logic idx_is_last; // sweep index sits on the last payload byte
  } tfr_sts_t;

endpackage

// ===== src/tfr_if.sv =====
interface tfr_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [tfr_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface tfr_out_if;
  logic                        valid;
  logic                        ready;
  logic [tfr_pkg::BYTE_W-1:0]  payload_byte;
  logic                        checksum_good;
  logic                        packet_ready;
  logic                        last_of_run;

  modport source (output valid, output payload_byte, output checksum_good,
                  output packet_ready, output last_of_run, input ready);
  modport sink   (input valid, input payload_byte, input checksum_good,
                  input packet_ready, input last_of_run, output ready);
endinterface

// ===== src/tfr_ctrl.sv =====
module tfr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_op_i,
  output logic              in_ready_o,
  input  tfr_pkg::tfr_sts_t sts_i,
  output tfr_pkg::tfr_cmd_t cmd_o
);

  tfr_pkg::tfr_state_e state_q, state_d;
  logic                accept;

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tfr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tfr_pkg::ST_IDLE: begin
        if (accept && (in_op_i == tfr_pkg::OP_FETCH)) begin
          state_d = tfr_pkg::ST_SUM_RD;
        end
      end
      tfr_pkg::ST_SUM_RD: begin
        state_d = tfr_pkg::ST_SUM_ACC;
      end
      tfr_pkg::ST_SUM_ACC: begin
        state_d = sts_i.idx_is_chk ? tfr_pkg::ST_STR_RD : tfr_pkg::ST_SUM_RD;
      end
      tfr_pkg::ST_STR_RD: begin
        state_d = tfr_pkg::ST_STR_EMIT;
      end
      tfr_pkg::ST_STR_EMIT: begin
        if (sts_i.out_free) begin
          state_d = sts_i.idx_is_last ? tfr_pkg::ST_IDLE : tfr_pkg::ST_STR_RD;
        end
      end
      default: begin
        state_d = tfr_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      tfr_pkg::ST_IDLE: begin
        in_ready_o = sts_i.out_free;
        if (accept) begin
          cmd_o.byte_op     = (in_op_i == tfr_pkg::OP_RX_BYTE);
          cmd_o.fetch_start = (in_op_i == tfr_pkg::OP_FETCH);
        end
      end
      tfr_pkg::ST_SUM_RD: begin
        cmd_o.rd_en = 1'b1;
      end
      tfr_pkg::ST_SUM_ACC: begin
        cmd_o.acc = 1'b1;
      end
      tfr_pkg::ST_STR_RD: begin
        cmd_o.rd_en = 1'b1;
      end
      tfr_pkg::ST_STR_EMIT: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != tfr_pkg::ST_IDLE) |-> !in_ready_o)
    else $error("input ready outside idle");

  a_acc_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tfr_pkg::ST_SUM_ACC) |-> ($past(state_q) == tfr_pkg::ST_SUM_RD))
    else $error("accumulate without a preceding store read");

  a_fetch_starts_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fetch_start |=> (state_q == tfr_pkg::ST_SUM_RD))
    else $error("fetch did not start the checksum sweep");

endmodule

// ===== src/tfr_dpath.sv =====
module tfr_dpath #(
  parameter int unsigned PAYLOAD_BYTES = 20
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tfr_pkg::tfr_cmd_t               cmd_i,
  output tfr_pkg::tfr_sts_t               sts_o,
  input  logic [tfr_pkg::BYTE_W-1:0]      rx_byte_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [tfr_pkg::BYTE_W-1:0]      payload_byte_o,
  output logic                            checksum_good_o,
  output logic                            packet_ready_o,
  output logic                            last_of_run_o,
  input  logic                            cfg_we_i,
  input  logic [tfr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tfr_pkg::BYTE_W-1:0]      cfg_data_i
);

  localparam int unsigned FRAME = PAYLOAD_BYTES + 1;
  localparam int unsigned AW    = $clog2(FRAME);
  localparam int unsigned CW    = $clog2(FRAME + 1);

  logic [tfr_pkg::BYTE_W-1:0] sof_byte_q, chk_offset_q;

  tfr_pkg::tfr_phase_e phase_q, phase_d;
  logic [CW-1:0]       bc_q, bc_d;
  logic [AW-1:0]       idx_q;
  logic [tfr_pkg::BYTE_W-1:0] sum_q, sum_exp;
  logic                chk_good_q;

  logic [tfr_pkg::BYTE_W-1:0] mem [FRAME];
  logic [FRAME-1:0]           vld_q;
  logic                       mem_we;
  logic [tfr_pkg::BYTE_W-1:0] rd_data_q, rd_byte;
  logic                       rd_vld_q;

  logic                       out_valid_q, out_good_q, out_ready_q, out_last_q;
  logic [tfr_pkg::BYTE_W-1:0] out_data_q;
  logic                       out_load;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sof_byte_q   <= tfr_pkg::SOF_BYTE_RST;
      chk_offset_q <= tfr_pkg::CHK_OFFSET_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tfr_pkg::CFG_SOF_BYTE:   sof_byte_q   <= cfg_data_i;
        tfr_pkg::CFG_CHK_OFFSET: chk_offset_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Framing: phase and byte counter, advanced by a received byte and cleared by a fetch.
  always_comb begin
    phase_d = phase_q;
    bc_d    = bc_q;
    mem_we  = 1'b0;
    if (cmd_i.fetch_start) begin
      phase_d = tfr_pkg::PH_HUNT;
      bc_d    = '0;
    end else if (cmd_i.byte_op) begin
      case (phase_q)
        tfr_pkg::PH_HUNT: begin
          if (rx_byte_i == sof_byte_q) begin
            phase_d = tfr_pkg::PH_COLLECT;
          end
        end
        tfr_pkg::PH_COLLECT: begin
          if (bc_q < CW'(FRAME)) begin
            mem_we = 1'b1;
            bc_d   = bc_q + CW'(1);
            if (bc_d == CW'(FRAME)) begin
              phase_d = tfr_pkg::PH_HELD;
              bc_d    = '0;
            end
          end else begin
            bc_d = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tfr_pkg::PH_HUNT;
      bc_q    <= '0;
      vld_q   <= '0;
    end else begin
      phase_q <= phase_d;
      bc_q    <= bc_d;
      if (mem_we) begin
        vld_q[bc_q[AW-1:0]] <= 1'b1;
      end
    end
  end

  // Frame store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[bc_q[AW-1:0]] <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[idx_q];
      rd_vld_q  <= vld_q[idx_q];
    end
  end

  // An entry never written reads as zero.
  assign rd_byte = rd_vld_q ? rd_data_q : '0;
  assign sum_exp = sum_q + chk_offset_q;

  // Sweep index, running sum and checksum verdict.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      sum_q      <= '0;
      chk_good_q <= 1'b0;
    end else if (cmd_i.fetch_start) begin
      idx_q <= '0;
      sum_q <= '0;
    end else if (cmd_i.acc) begin
      if (idx_q == AW'(PAYLOAD_BYTES)) begin
        chk_good_q <= (rd_byte == sum_exp);
        idx_q      <= '0;
      end else begin
        sum_q <= sum_q + rd_byte;
        idx_q <= idx_q + AW'(1);
      end
    end else if (cmd_i.emit) begin
      idx_q <= idx_q + AW'(1);
    end
  end

  // Output register.
  assign out_load = cmd_i.byte_op || cmd_i.emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.byte_op) begin
      out_data_q  <= '0;
      out_good_q  <= 1'b0;
      out_ready_q <= (phase_d == tfr_pkg::PH_HELD);
      out_last_q  <= 1'b1;
    end else if (cmd_i.emit) begin
      out_data_q  <= chk_good_q ? rd_byte : '0;
      out_good_q  <= chk_good_q;
      out_ready_q <= 1'b0;
      out_last_q  <= sts_o.idx_is_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_byte_o  = out_data_q;
  assign checksum_good_o = out_good_q;
  assign packet_ready_o  = out_ready_q;
  assign last_of_run_o   = out_last_q;

  assign sts_o.out_free    = !out_valid_q || out_ready_i;
  assign sts_o.idx_is_chk  = (idx_q == AW'(PAYLOAD_BYTES));
  assign sts_o.idx_is_last = (idx_q == AW'(PAYLOAD_BYTES - 1));

  a_count_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bc_q < CW'(FRAME))
    else $error("byte counter ran past the frame");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("result posted over an untaken result");

  a_held_flag_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ready_q) |-> (out_last_q && !out_good_q && (out_data_q == '0)))
    else $error("packet ready flag on a fetch result");

endmodule

// ===== src/telemetry_frame_receiver.sv =====
// Telemetry frame receiver. Input beats carry either a received serial byte
// (operation 0) or a fetch request (operation 1). While hunting, a byte equal
// to the start-of-frame register opens a frame; the next PAYLOAD_BYTES bytes
// and one checksum byte are then stored, after which the frame is held and
// further bytes are ignored until a fetch. Every received byte yields exactly
// one result beat with zero data, which reports in packet_ready whether a
// frame is held. A fetch checks that the checksum byte equals the 8-bit sum of
// the payload plus checksum_offset, then streams PAYLOAD_BYTES result beats
// carrying the payload (or zeros on a mismatch) with checksum_good, and
// last_of_run set on the final beat; the receiver then hunts again with its
// byte counter cleared. A fetch with no frame held works on the store as it
// stands, and store entries never written read as zero. A received byte leaves
// the sequencer idle. A fetch occupies the input, longer under output stall,
// for its acceptance, a checksum pass with a store read and an accumulate step
// for each store entry, and then a store read and an emit step per payload
// beat, because the frame store has a single registered read port that both
// passes share. No input beat is taken while a fetch runs.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i and must
// only be changed while the block is idle.
module telemetry_frame_receiver #(
  parameter int unsigned PAYLOAD_BYTES = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tfr_in_if.sink                        in_i,
  tfr_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [tfr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tfr_pkg::BYTE_W-1:0]    cfg_data_i
);

  // Command and status between the sequencer and the datapath.
  tfr_pkg::tfr_cmd_t cmd;
  tfr_pkg::tfr_sts_t sts;

  // The sequencer takes an input beat only while idle and with room in the
  // output register, and walks the checksum pass and the payload stream.
  tfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.operation),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the framing state, the frame store, the running sum
  // and the output register.
  tfr_dpath #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .rx_byte_i       (in_i.rx_byte),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .payload_byte_o  (out_o.payload_byte),
    .checksum_good_o (out_o.checksum_good),
    .packet_ready_o  (out_o.packet_ready),
    .last_of_run_o   (out_o.last_of_run),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

  // The block is built with its default frame size; the model below keeps the
  // same size so that the fetch sweep and the checksum slot line up.
  localparam int unsigned PAYLOAD_BYTES  = 20;
  localparam int unsigned FRAME_BYTES    = PAYLOAD_BYTES + 1;
  localparam int unsigned CLK_PERIOD     = 20;
  localparam int unsigned ITEMS_TARGET   = 310;
  localparam int unsigned IDLE_PERCENT   = 36;
  localparam int unsigned STALL_CYCLES   = 300;
  // A fetch is the slowest thing the block does: a checksum pass over the
  // whole store, then a read and an emit step per payload beat. After the
  // last beat we wait about as long as a fetch, then reconfigure or end.
  localparam int unsigned SETTLE_CYCLES  = 4 * PAYLOAD_BYTES + 8;
  localparam int unsigned TIMEOUT_CYCLES = 1_000_000;

  typedef logic [tfr_pkg::BYTE_W-1:0] tb_byte_t;

  // One result beat as the block presents it on its output channel.
  typedef struct packed {
    logic [tfr_pkg::BYTE_W-1:0] payload_byte;
    logic                       checksum_good;
    logic                       packet_ready;
    logic                       last_of_run;
  } rx_beat_t;

  logic clk_i;
  logic rst_ni;
  logic                          cfg_we_i;
  logic [tfr_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [tfr_pkg::BYTE_W-1:0]    cfg_data_i;

  tfr_in_if  in_if ();
  tfr_out_if out_if ();

  telemetry_frame_receiver #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Our own copy of the receiver: registers, framing phase, byte counter and
  // the frame store (payload bytes followed by the checksum byte).
  tb_byte_t            mdl_start;
  tb_byte_t            mdl_offset;
  tfr_pkg::tfr_phase_e mdl_phase;
  int unsigned         mdl_count;
  tb_byte_t            mdl_store [FRAME_BYTES];

  // Result beats predicted for accepted input beats, oldest first.
  rx_beat_t rx_beats_q [$];

  // Run bookkeeping.
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned beats_checked;
  int unsigned fetches_good;
  int unsigned fetches_bad;
  int unsigned settings_applied;

  // Idling control shared by both sides, and the request for a long hold-off
  // on the output side.
  bit idle_gaps;
  bit stall_req;
  int unsigned stall_left;

  // The clock runs freely from time zero.
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // A hard ceiling on the run, well beyond the slowest legal schedule.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("CHECKS FAILED");
    $finish;
  end

  // A random byte value.
  function automatic tb_byte_t rand_byte();
    return tb_byte_t'($urandom_range(255));
  endfunction

  // Works out the result beats that one accepted input beat causes and
  // advances the model. A received byte always yields a single beat with zero
  // data; a fetch yields a full payload sweep and puts the receiver back into
  // the hunt phase with its counter cleared, whether or not a frame was held.
  function automatic void predict_rx_beats(input logic op, input tb_byte_t rx);
    tb_byte_t sum;
    logic     good;
    rx_beat_t beat;
    int       i;
    if (op == tfr_pkg::OP_RX_BYTE) begin
      case (mdl_phase)
        tfr_pkg::PH_HUNT: begin
          if (rx == mdl_start) mdl_phase = tfr_pkg::PH_COLLECT;
        end
        tfr_pkg::PH_COLLECT: begin
          // The start byte is just data once a frame has been opened.
          mdl_store[mdl_count] = rx;
          mdl_count++;
          if (mdl_count == FRAME_BYTES) begin
            mdl_phase = tfr_pkg::PH_HELD;
            mdl_count = 0;
          end
        end
        default: begin
          // A held frame ignores further bytes until it is fetched.
        end
      endcase
      beat.payload_byte  = '0;
      beat.checksum_good = 1'b0;
      beat.packet_ready  = (mdl_phase == tfr_pkg::PH_HELD);
      beat.last_of_run   = 1'b1;
      rx_beats_q.push_back(beat);
    end else begin
      // The store is evaluated as it stands, which after an early fetch may be
      // an older frame or one that is only partly overwritten.
      sum = mdl_offset;
      for (i = 0; i < PAYLOAD_BYTES; i++) sum = sum + mdl_store[i];
      good = (mdl_store[PAYLOAD_BYTES] == sum);
      if (good) fetches_good++;
      else      fetches_bad++;
      mdl_phase = tfr_pkg::PH_HUNT;
      mdl_count = 0;
      for (i = 0; i < PAYLOAD_BYTES; i++) begin
        beat.payload_byte  = good ? mdl_store[i] : '0;
        beat.checksum_good = good;
        beat.packet_ready  = 1'b0;
        beat.last_of_run   = (i == PAYLOAD_BYTES - 1);
        rx_beats_q.push_back(beat);
      end
    end
  endfunction

  // Offers one input beat, with a random gap in front of it when idling is
  // enabled, and holds it until the block takes it. Valid is left high after
  // the beat is taken so that back-to-back beats need no second assignment in
  // the same time step; whoever stops sending lowers it.
  task automatic send_beat(input logic op, input tb_byte_t rx);
    while (idle_gaps && ($urandom_range(99) < IDLE_PERCENT)) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.rx_byte   <= rx;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_sent++;
    predict_rx_beats(op, rx);
  endtask

  // Stops offering beats and waits until every predicted beat has been seen,
  // then lets the block settle.
  task automatic drain_block();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (rx_beats_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes one configuration register; the block must be idle.
  task automatic write_reg(input logic [tfr_pkg::CFG_IDX_W-1:0] idx, input tb_byte_t data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == tfr_pkg::CFG_SOF_BYTE) mdl_start  = data;
    else                              mdl_offset = data;
  endtask

  // Drains the block and then changes both registers.
  task automatic apply_setting(input tb_byte_t start, input tb_byte_t offset);
    drain_block();
    write_reg(tfr_pkg::CFG_SOF_BYTE, start);
    write_reg(tfr_pkg::CFG_CHK_OFFSET, offset);
    settings_applied++;
  endtask

  // Sends one well-formed frame with random content: start byte, payload,
  // checksum (right or deliberately wrong), held_extra bytes while the frame
  // is held, and the fetch. If the receiver is not hunting, a fetch first puts
  // it back into the hunt phase so that the frame lines up.
  task automatic send_frame(input bit sum_ok, input int unsigned held_extra);
    tb_byte_t sum;
    tb_byte_t b;
    int       i;
    if (mdl_phase != tfr_pkg::PH_HUNT) send_beat(tfr_pkg::OP_FETCH, rand_byte());
    sum = mdl_offset;
    send_beat(tfr_pkg::OP_RX_BYTE, mdl_start);
    for (i = 0; i < PAYLOAD_BYTES; i++) begin
      // Now and then the start byte turns up inside the payload.
      b = ($urandom_range(7) == 0) ? mdl_start : rand_byte();
      sum = sum + b;
      send_beat(tfr_pkg::OP_RX_BYTE, b);
    end
    if (!sum_ok) sum = sum + tb_byte_t'($urandom_range(1, 255));
    send_beat(tfr_pkg::OP_RX_BYTE, sum);
    for (i = 0; i < held_extra; i++) send_beat(tfr_pkg::OP_RX_BYTE, rand_byte());
    send_beat(tfr_pkg::OP_FETCH, rand_byte());
  endtask

  // The output side: ready idles at random, holds off for a long stretch on
  // request, and stays high throughout when idling is switched off.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (stall_req) begin
        stall_req  = 1'b0;
        stall_left = STALL_CYCLES - 1;
        out_if.ready <= 1'b0;
      end else if (!idle_gaps) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Every accepted result beat is compared field by field with the oldest
  // prediction. A beat with nothing predicted is a failure in its own right.
  always @(posedge clk_i) begin
    rx_beat_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (rx_beats_q.size() == 0) begin
        $error("unexpected result beat: payload_byte %0h", out_if.payload_byte);
        fail_count++;
      end else begin
        want = rx_beats_q.pop_front();
        beats_checked++;
        if (out_if.payload_byte !== want.payload_byte) begin
          $error("payload_byte: expected %0h, got %0h", want.payload_byte,
                 out_if.payload_byte);
          fail_count++;
        end
        if (out_if.checksum_good !== want.checksum_good) begin
          $error("checksum_good: expected %0b, got %0b", want.checksum_good,
                 out_if.checksum_good);
          fail_count++;
        end
        if (out_if.packet_ready !== want.packet_ready) begin
          $error("packet_ready: expected %0b, got %0b", want.packet_ready,
                 out_if.packet_ready);
          fail_count++;
        end
        if (out_if.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                 out_if.last_of_run);
          fail_count++;
        end
      end
    end
  end

  // Directed opening at the reset settings. The very first beat is a fetch
  // with no frame held: the store is still all zeros and a zero offset makes
  // its checksum match, so a full run of zero bytes with checksum_good comes
  // back. Then a byte that is not the start byte is ignored while hunting, a
  // frame is opened whose payload carries both byte extremes and the start
  // byte itself as data, a byte arriving while the frame is held is ignored,
  // and the frame is fetched.
  task automatic test_directed_frame();
    tb_byte_t sum;
    tb_byte_t b;
    int       i;
    send_beat(tfr_pkg::OP_FETCH, 8'hff);
    send_beat(tfr_pkg::OP_RX_BYTE, 8'h00);
    send_beat(tfr_pkg::OP_RX_BYTE, mdl_start);
    sum = mdl_offset;
    for (i = 0; i < PAYLOAD_BYTES; i++) begin
      case (i)
        0:       b = 8'hff;
        1:       b = 8'h00;
        2:       b = mdl_start;
        default: b = tb_byte_t'(i * 37);
      endcase
      sum = sum + b;
      send_beat(tfr_pkg::OP_RX_BYTE, b);
    end
    send_beat(tfr_pkg::OP_RX_BYTE, sum);
    send_beat(tfr_pkg::OP_RX_BYTE, 8'hff);
    send_beat(tfr_pkg::OP_FETCH, 8'h00);
  endtask

  // Both registers at their extremes and in between, with one matching and
  // one failing frame for each extreme setting and a matching one in between.
  task automatic test_register_extremes();
    apply_setting(8'h00, 8'hff);
    send_frame(1'b1, 1);
    send_frame(1'b0, 0);
    apply_setting(8'hff, 8'h00);
    send_frame(1'b0, 2);
    send_frame(1'b1, 0);
    apply_setting(8'ha5, 8'h5a);
    send_frame(1'b1, 0);
  endtask

  // The output side holds off for a long stretch while bytes and a fetch keep
  // being offered, so the block fills up and stops taking input.
  task automatic test_output_stall();
    int i;
    drain_block();
    stall_req = 1'b1;
    for (i = 0; i < 6; i++) send_beat(tfr_pkg::OP_RX_BYTE, rand_byte());
    send_frame(($urandom_range(1) == 1), 1);
  endtask

  // A stretch with no idling at all on either side.
  task automatic test_no_idle_stretch();
    idle_gaps = 1'b0;
    send_frame(1'b1, 0);
    send_frame(1'b0, 1);
    send_frame(($urandom_range(1) == 1), $urandom_range(2));
    idle_gaps = 1'b1;
  endtask

  // Random traffic, mostly well-formed frames, with fetches that cut a frame
  // short, loose noise beats, and now and then a fresh random setting.
  task automatic test_random_traffic();
    int unsigned kind;
    int unsigned n;
    int          i;
    while (items_sent < ITEMS_TARGET) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        send_frame(($urandom_range(1) == 1), $urandom_range(2));
      end else if (kind < 85) begin
        // A fetch before the frame is complete works on a partly overwritten
        // store.
        if (mdl_phase != tfr_pkg::PH_HUNT) send_beat(tfr_pkg::OP_FETCH, rand_byte());
        send_beat(tfr_pkg::OP_RX_BYTE, mdl_start);
        n = $urandom_range(FRAME_BYTES - 1);
        for (i = 0; i < n; i++) send_beat(tfr_pkg::OP_RX_BYTE, rand_byte());
        send_beat(tfr_pkg::OP_FETCH, rand_byte());
      end else begin
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++)
          send_beat(($urandom_range(3) == 0) ? tfr_pkg::OP_FETCH : tfr_pkg::OP_RX_BYTE,
                    rand_byte());
      end
      if ($urandom_range(9) == 0) apply_setting(rand_byte(), rand_byte());
    end
  endtask

  initial begin
    idle_gaps        = 1'b1;
    stall_req        = 1'b0;
    stall_left       = 0;
    fail_count       = 0;
    items_sent       = 0;
    beats_checked    = 0;
    fetches_good     = 0;
    fetches_bad      = 0;
    settings_applied = 0;
    mdl_start        = tfr_pkg::SOF_BYTE_RST;
    mdl_offset       = tfr_pkg::CHK_OFFSET_RST;
    mdl_phase        = tfr_pkg::PH_HUNT;
    mdl_count        = 0;
    foreach (mdl_store[i]) mdl_store[i] = '0;

    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.operation <= tfr_pkg::OP_RX_BYTE;
    in_if.rx_byte   <= '0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= tfr_pkg::CFG_SOF_BYTE;
    cfg_data_i      <= '0;

    // Reset is released on a rising edge.
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_frame();
    test_register_extremes();
    test_output_stall();
    test_no_idle_stretch();
    test_random_traffic();

    drain_block();
    if (rx_beats_q.size() != 0) begin
      $error("%0d predicted result beats never arrived", rx_beats_q.size());
      fail_count += rx_beats_q.size();
    end

    $display("Run covered %0d input beats and %0d result beats over %0d register settings.",
             items_sent, beats_checked, settings_applied + 1);
    $display("Fetches with a matching checksum: %0d, with a mismatch: %0d.",
             fetches_good, fetches_bad);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
